@@ hw/rtl/nearest_palette_color_search_macros.svh @@
// Assertion macros for the palette search block.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication.
`define NPCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/npcs_pkg.sv @@
package npcs_pkg;

	localparam int IDX_W     = 8;
	localparam int COLOR_W   = 32;
	localparam int DIST_W    = 18;
	localparam int SIZE_W    = 9;
	localparam int NUM_CHANNELS = 4;

	localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 9'd256;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [0:0] REG_PALETTE_SIZE = 1'b0;

	typedef struct packed {
		logic               cmd;
		logic [IDX_W-1:0]   entry_index;
		logic [COLOR_W-1:0] color_rgba;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
	} out_t;

endpackage

@@ hw/rtl/npcs_ram.sv @@
module npcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/nearest_palette_color_search.sv @@
// Nearest palette color search.
// Command channel: an item transfers at a rising edge with start high and busy low.
// cmd = load writes color_rgba into palette slot entry_index and gives no result;
// slots at or above PALETTE_DEPTH are not written.
// cmd = query compares color_rgba with palette entries 0 .. n-1, where n is
// palette_size clamped to 1 .. PALETTE_DEPTH, and returns the closest index
// (lowest on ties) and its squared RGBA distance.
// A query holds busy high and walks the palette memory one entry per cycle
// through its single read port; result_valid then pulses for one cycle, and busy
// falls at the edge that raises it, so the next command can transfer in the strobe
// cycle. Loads do not raise busy. The receiver cannot stall: result is valid only
// in the strobe cycle. palette_size is written through the APB port (register 0,
// reset 256); the user must write it only while the block is idle, which the block
// itself does not enforce. Reset clears control state and sets palette_size to
// 256; palette contents are undefined until loaded.
`include "nearest_palette_color_search_macros.svh"

module nearest_palette_color_search #(
	parameter int PALETTE_DEPTH = 256,
	parameter int CHANNEL_BITS  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             start,
	input  npcs_pkg::in_t    item,
	output logic             busy,
	output logic             result_valid,
	output npcs_pkg::out_t   result
);

	localparam int AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SZW = npcs_pkg::SIZE_W;
	localparam int SW  = ((AW > SZW) ? AW : SZW) + 1;
	localparam int SQW = 2 * CHANNEL_BITS;
	localparam int DW  = 2 * CHANNEL_BITS + 2;
	localparam int NCH = npcs_pkg::NUM_CHANNELS;
	localparam int IW  = npcs_pkg::IDX_W;
	localparam int OW  = npcs_pkg::DIST_W;
	localparam int CW  = npcs_pkg::COLOR_W;

	logic [SZW-1:0] size_q;
	logic           cfg_wr;

	logic           accept;
	logic           load_we;
	logic           query_start;
	logic [SW-1:0]  size_ext;
	logic [SW-1:0]  depth_ext;
	logic [AW-1:0]  last_idx;

	logic           busy_q;
	logic           issue_q;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  last_q;
	logic [CW-1:0]  color_q;

	logic [CW-1:0]  rd_data;

	logic           valid_s1;
	logic           last_s1;
	logic [AW-1:0]  idx_s1;

	logic [63:0]             q_ext;
	logic [63:0]             e_ext;
	logic [CHANNEL_BITS-1:0] q_ch [NCH];
	logic [CHANNEL_BITS-1:0] e_ch [NCH];
	logic [CHANNEL_BITS-1:0] diff [NCH];

	logic           valid_s2;
	logic           last_s2;
	logic [AW-1:0]  idx_s2;
	logic [SQW-1:0] sq_s2 [NCH];

	logic [DW-1:0]  dist_sum;
	logic           take_new;
	logic [DW-1:0]  sel_d;
	logic [AW-1:0]  sel_i;
	logic [DW-1:0]  best_d_q;
	logic [AW-1:0]  best_i_q;

	logic           result_valid_q;
	npcs_pkg::out_t result_q;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2:2] == npcs_pkg::REG_PALETTE_SIZE) ? 32'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= npcs_pkg::PALETTE_SIZE_RESET;
		end else if (cfg_wr && paddr[2:2] == npcs_pkg::REG_PALETTE_SIZE) begin
			size_q <= pwdata[SZW-1:0];
		end
	end

	// Command transfer
	assign accept      = start && !busy_q;
	assign load_we     = accept && item.cmd == npcs_pkg::CMD_LOAD &&
	                     SW'(item.entry_index) < depth_ext;
	assign query_start = accept && item.cmd == npcs_pkg::CMD_QUERY;
	assign size_ext    = SW'(size_q);
	assign depth_ext   = SW'(PALETTE_DEPTH);

	always_comb begin
		priority if (size_ext == '0) begin
			last_idx = '0;
		end else if (size_ext > depth_ext) begin
			last_idx = AW'(depth_ext - SW'(1));
		end else begin
			last_idx = AW'(size_ext - SW'(1));
		end
	end

	npcs_ram #(
		.WIDTH (CW),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(item.entry_index)),
		.wdata (item.color_rgba),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	// Stage 1: channel differences and squares
	always_comb begin
		q_ext = 64'(color_q);
		e_ext = 64'(rd_data);
		for (int c = 0; c < NCH; c++) begin
			q_ch[c] = q_ext[c*CHANNEL_BITS +: CHANNEL_BITS];
			e_ch[c] = e_ext[c*CHANNEL_BITS +: CHANNEL_BITS];
			diff[c] = (q_ch[c] >= e_ch[c]) ? (q_ch[c] - e_ch[c]) : (e_ch[c] - q_ch[c]);
		end
	end

	// Stage 2: sum and compare
	always_comb begin
		dist_sum = '0;
		for (int c = 0; c < NCH; c++) begin
			dist_sum = dist_sum + DW'(sq_s2[c]);
		end
	end

	assign take_new = (idx_s2 == '0) || (dist_sum < best_d_q);
	assign sel_d    = take_new ? dist_sum : best_d_q;
	assign sel_i    = take_new ? idx_s2 : best_i_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			issue_q        <= 1'b0;
			addr_q         <= '0;
			last_q         <= '0;
			valid_s1       <= 1'b0;
			last_s1        <= 1'b0;
			valid_s2       <= 1'b0;
			last_s2        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= issue_q;
			last_s1        <= issue_q && addr_q == last_q;
			valid_s2       <= valid_s1;
			last_s2        <= last_s1;
			result_valid_q <= valid_s2 && last_s2;
			if (query_start) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				addr_q  <= '0;
				last_q  <= last_idx;
			end else begin
				if (issue_q) begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == last_q) begin
						issue_q <= 1'b0;
					end
				end
				if (valid_s2 && last_s2) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (query_start) begin
			color_q <= item.color_rgba;
		end
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		for (int c = 0; c < NCH; c++) begin
			sq_s2[c] <= SQW'(diff[c]) * SQW'(diff[c]);
		end
		if (valid_s2) begin
			best_d_q <= sel_d;
			best_i_q <= sel_i;
		end
		if (valid_s2 && last_s2) begin
			result_q.best_index    <= IW'(sel_i);
			result_q.best_distance <= OW'(sel_d);
		end
	end

	assign busy         = busy_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	`NPCS_ASSERT_SAME(a_strobe_idle, clk, arst_n, result_valid_q, !busy_q, "result while busy")
	`NPCS_ASSERT_NEXT(a_strobe_once, clk, arst_n, result_valid_q, !result_valid_q, "double result")
	`NPCS_ASSERT_SAME(a_issue_busy, clk, arst_n, issue_q || valid_s1 || valid_s2, busy_q,
		"search stage active while idle")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 256;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 420;
	localparam logic [2:0] SIZE_ADDR = 3'(4 * npcs_pkg::REG_PALETTE_SIZE);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	npcs_pkg::in_t item = '0;
	logic busy;
	logic result_valid;
	npcs_pkg::out_t result;

	logic [npcs_pkg::COLOR_W-1:0] palette_shadow [DEPTH];
	logic [npcs_pkg::SIZE_W-1:0] size_shadow = npcs_pkg::PALETTE_SIZE_RESET;
	npcs_pkg::out_t pending_nearest [$];

	int error_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int results_checked = 0;
	int size_writes = 0;
	int random_items = 0;

	nearest_palette_color_search i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int searched_entries();
		if (size_shadow == 0)
			return 1;
		if (size_shadow > DEPTH)
			return DEPTH;
		return int'(size_shadow);
	endfunction

	function automatic npcs_pkg::out_t predict_nearest(
			input logic [npcs_pkg::COLOR_W-1:0] color);
		npcs_pkg::out_t best;
		int best_dist;
		int sq_sum;
		int diff;
		best = '0;
		best_dist = -1;
		for (int i = 0; i < searched_entries(); i++) begin
			sq_sum = 0;
			for (int c = 0; c < npcs_pkg::NUM_CHANNELS; c++) begin
				diff = int'(color[c*8 +: 8]) - int'(palette_shadow[i][c*8 +: 8]);
				sq_sum += diff * diff;
			end
			if (best_dist < 0 || sq_sum < best_dist) begin
				best_dist = sq_sum;
				best.best_index = npcs_pkg::IDX_W'(i);
				best.best_distance = npcs_pkg::DIST_W'(sq_sum);
			end
		end
		return best;
	endfunction

	function automatic logic [npcs_pkg::COLOR_W-1:0] pick_color();
		logic [npcs_pkg::COLOR_W-1:0] color;
		case ($urandom_range(0, 3))
			0: begin
				for (int c = 0; c < npcs_pkg::NUM_CHANNELS; c++)
					color[c*8 +: 8] = 8'($urandom_range(0, 3) * 85);
			end
			1: begin
				for (int c = 0; c < npcs_pkg::NUM_CHANNELS; c++)
					case ($urandom_range(0, 3))
						0: color[c*8 +: 8] = 8'h00;
						1: color[c*8 +: 8] = 8'hff;
						2: color[c*8 +: 8] = 8'h80;
						default: color[c*8 +: 8] = 8'h7f;
					endcase
			end
			default: color = $urandom;
		endcase
		return color;
	endfunction

	// Inputs change right after the edge; busy read here is its pre-edge value.
	task automatic send_command(input logic cmd, input logic [npcs_pkg::IDX_W-1:0] slot,
			input logic [npcs_pkg::COLOR_W-1:0] color);
		npcs_pkg::in_t next_item;
		next_item.cmd = cmd;
		next_item.entry_index = slot;
		next_item.color_rgba = color;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 6);
		end
		burst_left--;
		start <= 1'b1;
		item <= next_item;
		do @(posedge clk); while (busy);
		if (cmd == npcs_pkg::CMD_LOAD) begin
			palette_shadow[slot] = color;
			loads_sent++;
		end else begin
			pending_nearest.push_back(predict_nearest(color));
			queries_sent++;
		end
	endtask

	task automatic load_entry(input int slot, input logic [npcs_pkg::COLOR_W-1:0] color);
		send_command(npcs_pkg::CMD_LOAD, npcs_pkg::IDX_W'(slot), color);
	endtask

	task automatic query_color(input logic [npcs_pkg::COLOR_W-1:0] color);
		send_command(npcs_pkg::CMD_QUERY, npcs_pkg::IDX_W'($urandom), color);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		burst_left = 0;
		while (pending_nearest.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_palette_size(input logic [npcs_pkg::SIZE_W-1:0] value);
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIZE_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_shadow = value;
		size_writes++;
	endtask

	// Fills every slot first, so no query can ever read an unloaded entry.
	task automatic test_default_size();
		for (int i = 0; i < DEPTH; i++)
			load_entry(i, pick_color());
		query_color(32'h0000_0000);
		query_color(32'hffff_ffff);
		query_color(palette_shadow[DEPTH-1]);
	endtask

	task automatic test_size_clamping();
		write_palette_size(9'd0);
		query_color($urandom);
		write_palette_size(9'd257);
		query_color($urandom);
		write_palette_size(9'd511);
		query_color(palette_shadow[DEPTH-1]);
		write_palette_size(9'd1);
		query_color($urandom);
	endtask

	task automatic test_ties_and_extremes();
		write_palette_size(9'd4);
		load_entry(0, 32'hffff_ffff);
		load_entry(1, 32'h0000_0000);
		load_entry(2, 32'h0000_0000);
		load_entry(3, 32'h8080_8080);
		query_color(32'h0000_0000);
		query_color(32'h4040_4040);
		query_color(32'hff00_0000);
		query_color(32'h00ff_0000);
		query_color(32'h0000_ff00);
		query_color(32'h0000_00ff);
		query_color(32'hffff_ffff);
		query_color(32'h7f7f_7f7f);
		write_palette_size(9'd1);
		load_entry(0, 32'hffff_ffff);
		query_color(32'h0000_0000);
	endtask

	task automatic test_random_traffic();
		int phase_items;
		int span;
		logic [npcs_pkg::SIZE_W-1:0] new_size;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					case ($urandom_range(0, 3))
						0: new_size = 9'd256;
						1: new_size = 9'd257;
						2: new_size = 9'd511;
						default: new_size = 9'd0;
					endcase
				end
				1: new_size = npcs_pkg::SIZE_W'($urandom_range(17, 128));
				default: new_size = npcs_pkg::SIZE_W'($urandom_range(1, 16));
			endcase
			write_palette_size(new_size);
			span = searched_entries();
			phase_items = (span > 128) ? $urandom_range(15, 30) : $urandom_range(30, 60);
			for (int k = 0; k < phase_items; k++) begin
				if ($urandom_range(0, 39) == 0)
					wait_quiet();
				case ($urandom_range(0, 9))
					0, 1, 2: load_entry($urandom_range(0, span - 1), pick_color());
					3: load_entry($urandom_range(0, DEPTH - 1), $urandom);
					4, 5: query_color(palette_shadow[$urandom_range(0, span - 1)]);
					6: query_color(palette_shadow[$urandom_range(0, span - 1)] ^
						($urandom & 32'h0303_0303));
					7: query_color(pick_color());
					default: query_color($urandom);
				endcase
				random_items++;
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		npcs_pkg::out_t want;
		if (arst_n && result_valid) begin
			if (pending_nearest.size() == 0) begin
				$error("result with no pending query: best_index %0d best_distance %0d",
					result.best_index, result.best_distance);
				error_count++;
			end else begin
				want = pending_nearest.pop_front();
				results_checked++;
				if (result.best_index !== want.best_index) begin
					$error("best_index expected %0d got %0d",
						want.best_index, result.best_index);
					error_count++;
				end
				if (result.best_distance !== want.best_distance) begin
					$error("best_distance expected %0d got %0d",
						want.best_distance, result.best_distance);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_size_clamping();
		test_ties_and_extremes();
		test_random_traffic();
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_nearest.size() != 0) begin
			$error("%0d query results never arrived", pending_nearest.size());
			error_count++;
		end
		$display("summary: %0d loads and %0d queries, %0d results compared",
			loads_sent, queries_sent, results_checked);
		$display("summary: %0d palette size writes incl. 0, 1, 257 and 511 after reset size 256",
			size_writes);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
